// ===== hw/rtl/esc_pkg.sv =====
// esc_pkg: shared types, constants and the month-length table of the
// epoch-seconds to calendar converter. No dependencies.
`default_nettype none

package esc_pkg;

	// Field widths
	localparam int unsigned EPOCH_W  = 32;
	localparam int unsigned ZONE_W   = 17;
	localparam int unsigned SUM_W    = 34;  // signed sum of epoch and zone offset
	localparam int unsigned REM_W    = 33;  // clamped sum is never negative
	localparam int unsigned QUO_W    = 17;  // whole days since the epoch
	localparam int unsigned TOD_W    = 17;  // second of the day
	localparam int unsigned MREM_W   = 12;  // second within the hour
	localparam int unsigned YEAR_W   = 12;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MIN_W    = 6;
	localparam int unsigned SEC_W    = 6;

	// Constants of the conversion
	localparam int unsigned SECS_PER_DAY  = 86400;
	localparam int unsigned SECS_PER_HOUR = 3600;
	localparam int unsigned SECS_PER_MIN  = 60;

	localparam logic signed [ZONE_W-1:0] ZONE_RESET = 17'sd28800;

	// Division by constants: drop the power-of-two factor of the divisor,
	// multiply by the rounded-up reciprocal of the odd factor, then shift.
	// Seconds to days: 86400 = 675 << 7, numerator below 2^26
	localparam int unsigned     DAY_PRE_SH = 7;
	localparam int unsigned     ODD_W      = 10;
	localparam logic [ODD_W-1:0] DAY_ODD   = 10'd675;
	localparam int unsigned     DAY_SH     = 36;
	localparam logic [26:0]     DAY_RECIP  = 27'd101806633;  // ceil(2^36 / 675)
	localparam int unsigned     DAY_PROD_W = 53;
	// Second of day to hour: 3600 = 225 << 4, numerator below 5400
	localparam int unsigned     HOUR_PRE_SH = 4;
	localparam int unsigned     HOUR_SH     = 21;
	localparam logic [13:0]     HOUR_RECIP  = 14'd9321;  // ceil(2^21 / 225)
	localparam int unsigned     HOUR_PROD_W = 27;
	// Second of hour to minute: 60 = 15 << 2, numerator below 900
	localparam int unsigned     MIN_PRE_SH = 2;
	localparam int unsigned     MIN_SH     = 14;
	localparam logic [10:0]     MIN_RECIP  = 11'd1093;  // ceil(2^14 / 15)
	localparam int unsigned     MIN_PROD_W = 21;

	// Start of the year walk, with the year's residues mod 100 and mod 400
	localparam logic [YEAR_W-1:0] EPOCH_YEAR    = 12'd1970;
	localparam logic [6:0]        EPOCH_MOD100  = 7'd70;
	localparam logic [8:0]        EPOCH_MOD400  = 9'd370;
	localparam logic [6:0]        MOD100_LAST   = 7'd99;
	localparam logic [8:0]        MOD400_LAST   = 9'd399;

	localparam logic [8:0] YEAR_DAYS      = 9'd365;
	localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic start;       // capture clamped sum
		logic day_div;     // whole days by reciprocal multiply
		logic load_hour;   // second of the day from the day count
		logic hour_div;    // hour by reciprocal multiply
		logic load_min;    // second within the hour
		logic min_div;     // minute by reciprocal multiply
		logic load_year;   // second of the minute, set up the year walk
		logic year_step;   // take one whole year off the day count
		logic month_step;  // take one whole month off the day count
		logic out_load;    // copy the finished result into the output register
	} esc_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic year_last;   // remaining days fall inside the current year
		logic month_last;  // remaining days fall inside the current month
	} esc_stat_t;

	// Days in a month, February by leap flag
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mon,
			input logic leap);
		logic [DAY_W-1:0] len;
		len = 5'd31;
		case (mon)
			MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/esc_dpath.sv =====
// esc_dpath: datapath of the converter: offset add and clamp, reciprocal
// multiply splits, year and month walk, output register. Uses esc_pkg.
`default_nettype none

module esc_dpath import esc_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic signed [ZONE_W-1:0]   cfg_wr_data,
	input  wire logic        [EPOCH_W-1:0]  epoch_seconds,
	input  wire esc_cmd_t                   cmd,
	output esc_stat_t                       stat,
	output logic             [YEAR_W-1:0]   year,
	output logic             [MONTH_W-1:0]  month,
	output logic             [DAY_W-1:0]    day_of_month,
	output logic             [HOUR_W-1:0]   hour,
	output logic             [MIN_W-1:0]    minute,
	output logic             [SEC_W-1:0]    second,
	output logic                            underflow
);

	logic signed [ZONE_W-1:0]      zone_q;

	logic        [REM_W-1:0]       sum_q;
	logic                          uf_q;
	logic        [TOD_W-1:0]       tod_q;
	logic        [MREM_W-1:0]      rem_q;

	logic        [QUO_W-1:0]       days_q;
	logic        [HOUR_W-1:0]      hour_q;
	logic        [MIN_W-1:0]       min_q;
	logic        [SEC_W-1:0]       sec_q;
	logic        [YEAR_W-1:0]      year_q;
	logic        [6:0]             mod100_q;
	logic        [8:0]             mod400_q;
	logic        [MONTH_W-1:0]     month_q;

	logic        [YEAR_W-1:0]      year_out_q;
	logic        [MONTH_W-1:0]     month_out_q;
	logic        [DAY_W-1:0]       day_out_q;
	logic        [HOUR_W-1:0]      hour_out_q;
	logic        [MIN_W-1:0]       min_out_q;
	logic        [SEC_W-1:0]       sec_out_q;
	logic                          uf_out_q;

	logic signed [SUM_W-1:0]       sum;
	logic                          sum_neg;
	logic        [DAY_PROD_W-1:0]  day_prod;
	logic        [ODD_W-1:0]       days_odd;
	logic        [HOUR_PROD_W-1:0] hour_prod;
	logic        [MREM_W-1:0]      hour_secs;
	logic        [MIN_PROD_W-1:0]  min_prod;
	logic        [SEC_W-1:0]       min_secs;
	logic                          leap;
	logic        [8:0]             ylen;
	logic        [DAY_W-1:0]       mlen;

	// Zone offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ZONE_RESET;
		end else if (cfg_wr_en) begin
			zone_q <= cfg_wr_data;
		end
	end

	// Offset add; a negative sum is clamped to zero
	assign sum     = signed'({2'b00, epoch_seconds}) + SUM_W'(zone_q);
	assign sum_neg = sum[SUM_W-1];

	// Quotients by reciprocal multiply; remainders only need their low bits
	assign day_prod  = DAY_PROD_W'(sum_q[REM_W-1:DAY_PRE_SH]) * DAY_PROD_W'(DAY_RECIP);
	assign days_odd  = ODD_W'(days_q) * DAY_ODD;
	assign hour_prod = HOUR_PROD_W'(tod_q[TOD_W-1:HOUR_PRE_SH]) * HOUR_PROD_W'(HOUR_RECIP);
	assign hour_secs = MREM_W'(hour_q) * MREM_W'(SECS_PER_HOUR);
	assign min_prod  = MIN_PROD_W'(rem_q[MREM_W-1:MIN_PRE_SH]) * MIN_PROD_W'(MIN_RECIP);
	assign min_secs  = SEC_W'(min_q) * SEC_W'(SECS_PER_MIN);

	// Gregorian leap rule from the tracked residues
	assign leap = ((year_q[1:0] == 2'b00) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
	assign ylen = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
	assign mlen = month_days(month_q, leap);

	assign stat = '{year_last:  (days_q < QUO_W'(ylen)),
			month_last: ((month_q >= MONTH_DEC) || (days_q < QUO_W'(mlen)))};

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sum_q <= sum_neg ? '0 : sum[REM_W-1:0];
			uf_q  <= sum_neg;
		end
		if (cmd.day_div) begin
			days_q <= day_prod[DAY_SH +: QUO_W];
		end
		// remainder of the odd factor, then the dropped low bits
		if (cmd.load_hour) begin
			tod_q <= {sum_q[DAY_PRE_SH +: ODD_W] - days_odd, sum_q[DAY_PRE_SH-1:0]};
		end
		if (cmd.hour_div) begin
			hour_q <= hour_prod[HOUR_SH +: HOUR_W];
		end
		if (cmd.load_min) begin
			rem_q <= tod_q[MREM_W-1:0] - hour_secs;
		end
		if (cmd.min_div) begin
			min_q <= min_prod[MIN_SH +: MIN_W];
		end
		if (cmd.load_year) begin
			sec_q    <= rem_q[SEC_W-1:0] - min_secs;
			year_q   <= EPOCH_YEAR;
			mod100_q <= EPOCH_MOD100;
			mod400_q <= EPOCH_MOD400;
			month_q  <= MONTH_JAN;
		end
		if (cmd.year_step) begin
			days_q   <= days_q - QUO_W'(ylen);
			year_q   <= year_q + 12'd1;
			mod100_q <= (mod100_q == MOD100_LAST) ? 7'd0 : mod100_q + 7'd1;
			mod400_q <= (mod400_q == MOD400_LAST) ? 9'd0 : mod400_q + 9'd1;
		end
		if (cmd.month_step) begin
			days_q  <= days_q - QUO_W'(mlen);
			month_q <= month_q + 4'd1;
		end
	end

	// Output register, day count becomes a 1-based day of month
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			year_out_q  <= year_q;
			month_out_q <= month_q;
			day_out_q   <= days_q[DAY_W-1:0] + 5'd1;
			hour_out_q  <= hour_q;
			min_out_q   <= min_q;
			sec_out_q   <= sec_q;
			uf_out_q    <= uf_q;
		end
	end

	assign year         = year_out_q;
	assign month        = month_out_q;
	assign day_of_month = day_out_q;
	assign hour         = hour_out_q;
	assign minute       = min_out_q;
	assign second       = sec_out_q;
	assign underflow    = uf_out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/esc_ctrl.sv =====
// esc_ctrl: sequencer of the converter. Steps the datapath through the
// day and time split, the year walk and the month walk. Uses esc_pkg.
`default_nettype none

module esc_ctrl import esc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire esc_stat_t stat,
	output esc_cmd_t       cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DAY,
		ST_HLD,
		ST_HOUR,
		ST_MLD,
		ST_MIN,
		ST_YLD,
		ST_YEAR,
		ST_MONTH,
		ST_OUT
	} state_t;

	state_t           state_q;
	logic             out_valid_q;
	logic             out_free;

	// Output register can take a new result
	assign out_free = !out_valid_q || !out_stall;

	// Command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.start      = in_valid;
			ST_DAY:   cmd.day_div    = 1'b1;
			ST_HLD:   cmd.load_hour  = 1'b1;
			ST_HOUR:  cmd.hour_div   = 1'b1;
			ST_MLD:   cmd.load_min   = 1'b1;
			ST_MIN:   cmd.min_div    = 1'b1;
			ST_YLD:   cmd.load_year  = 1'b1;
			ST_YEAR:  cmd.year_step  = !stat.year_last;
			ST_MONTH: cmd.month_step = !stat.month_last;
			ST_OUT:   cmd.out_load   = out_free;
			default:  cmd = '0;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DAY;
				end
				ST_DAY: begin
					state_q <= ST_HLD;
				end
				ST_HLD: begin
					state_q <= ST_HOUR;
				end
				ST_HOUR: begin
					state_q <= ST_MLD;
				end
				ST_MLD: begin
					state_q <= ST_MIN;
				end
				ST_MIN: begin
					state_q <= ST_YLD;
				end
				ST_YLD: begin
					state_q <= ST_YEAR;
				end
				ST_YEAR: begin
					if (stat.year_last) state_q <= ST_MONTH;
				end
				ST_MONTH: begin
					if (stat.month_last) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// A new result appears only when the sequencer hands one over
	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("out_valid rose without a result hand-over");

	// The day split state is always followed by the hour load state
	a_day_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DAY) |=> (state_q == ST_HLD))
		else $error("day split did not advance");

	// An accepted item starts the day split at once
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> (state_q == ST_DAY))
		else $error("accepted item did not start the day split");

	// A finished result waits while the previous one is still held
	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && out_stall) |=> (state_q == ST_OUT))
		else $error("result overwrote a stalled output");

endmodule

`default_nettype wire

// ===== hw/rtl/epoch_seconds_to_calendar_unit.sv =====
// epoch_seconds_to_calendar_unit: top level of the epoch-seconds to calendar
// converter. Depends on esc_pkg, esc_ctrl and esc_dpath.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  input    | in_valid / in_stall       | epoch_seconds
//  output   | out_valid / out_stall     | year month day_of_month hour minute
//           |                           | second underflow
//  config   | cfg_wr_en                 | cfg_wr_data (zone offset, signed)
//
// An item goes from transfer to result through the day and time split (day,
// hour and minute division with their loads), the year walk, one year per
// cycle for up to 136 years after 1970, and the month walk.
// One item is worked on at a time; the next input transfer is taken while a
// finished result still waits in the output register, and the following
// result waits in the sequencer until that one leaves.
// Reset sets the zone offset to +8 hours and clears all handshake state.
`default_nettype none

module epoch_seconds_to_calendar_unit import esc_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic signed [ZONE_W-1:0]  cfg_wr_data,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic        [EPOCH_W-1:0] epoch_seconds,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic             [YEAR_W-1:0]  year,
	output logic             [MONTH_W-1:0] month,
	output logic             [DAY_W-1:0]   day_of_month,
	output logic             [HOUR_W-1:0]  hour,
	output logic             [MIN_W-1:0]   minute,
	output logic             [SEC_W-1:0]   second,
	output logic                           underflow
);

	esc_cmd_t  cmd;
	esc_stat_t stat;

	// Sequencer
	esc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath
	esc_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.epoch_seconds (epoch_seconds),
		.cmd           (cmd),
		.stat          (stat),
		.year          (year),
		.month         (month),
		.day_of_month  (day_of_month),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.underflow     (underflow)
	);

endmodule

`default_nettype wire
